// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent on one edge implies consequent on the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/lrupc_pkg.sv
// ----------------------------------------------------------------------------
// lrupc_pkg
// shared types and constants of the lru tracker with pin counts
// ----------------------------------------------------------------------------
package lrupc_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 64;
  localparam int PIN_BITS_DEF   = 8;
  localparam int MAX_SCAN_RESET = 128;

  typedef enum logic [2:0] {
    OP_ACCESS = 3'd0,
    OP_EVICT  = 3'd1,
    OP_DELETE = 3'd2,
    OP_REF    = 3'd3,
    OP_UNREF  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_NONE      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPDATE,
    S_DONE
  } fsm_t;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_FRONT,
    UPD_INSERT,
    UPD_REMOVE,
    UPD_UNREF
  } upd_mode_t;

  typedef struct packed {
    upd_mode_t mode;
    logic      is_ref;
  } upd_ctrl_t;

endpackage

// File: hdl/lrupc_ram.sv
// ----------------------------------------------------------------------------
// lrupc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lrupc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/lrupc_update.sv
// ----------------------------------------------------------------------------
// lrupc_update
// per-entry rank and pin count rewrite for the write-back sweep
// ----------------------------------------------------------------------------
module lrupc_update import lrupc_pkg::*; #(
  parameter int AW       = 4,
  parameter int PIN_BITS = PIN_BITS_DEF
) (
  input  upd_ctrl_t           ctrl,
  input  logic [AW-1:0]       idx,
  input  logic                valid,
  input  logic [AW-1:0]       fslot,
  input  logic [AW-1:0]       frank,
  input  logic [AW-1:0]       free_slot,
  input  logic [AW-1:0]       rank_in,
  input  logic [PIN_BITS-1:0] pins_in,
  output logic [AW-1:0]       rank_out,
  output logic [PIN_BITS-1:0] pins_out
);

  always_comb begin
    rank_out = rank_in;
    pins_out = pins_in;
    unique case (ctrl.mode)
      UPD_FRONT: begin
        if (idx == fslot) begin
          rank_out = '0;
          if (ctrl.is_ref && pins_in != '1) begin
            pins_out = pins_in + 1'b1;
          end
        end else if (valid && rank_in < frank) begin
          rank_out = rank_in + 1'b1;
        end
      end
      UPD_INSERT: begin
        if (idx == free_slot) begin
          rank_out = '0;
          pins_out = '0;
        end else if (valid) begin
          rank_out = rank_in + 1'b1;
        end
      end
      UPD_REMOVE: begin
        if (valid && rank_in > frank) begin
          rank_out = rank_in - 1'b1;
        end
      end
      UPD_UNREF: begin
        if (idx == fslot && pins_in != '0) begin
          pins_out = pins_in - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/lru_tracker_with_pin_counts_core.sv
// ----------------------------------------------------------------------------
// lru_tracker_with_pin_counts_core
// lru-ordered key table with saturating pin counts, memory based
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; each one yields
// exactly one result, shown for a single cycle with done high, and the
// receiver cannot stall it. Keys live in one ram and rank/pin metadata in a
// second; valid bits and the occupancy count are flip-flops. Every operation
// runs a read sweep over all ENTRIES slots (key match, eviction candidate,
// lowest free slot), a decision state, a read-modify-write sweep over the
// metadata ram, and a commit state. Both sweeps step one slot per cycle
// behind the registered ram read; busy stays high from the first sweep
// through the commit, so no new transaction is taken until the commit is over.
// The result shows in the first idle cycle, which can also take the next
// transaction. max_scan is written through cfg_valid/cfg_data (always
// ready) by the user only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_tracker_with_pin_counts_core import lrupc_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int PIN_BITS = PIN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [63:0] key,
  output logic        done,
  output logic [1:0]  status,
  output logic [63:0] victim_key,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int LW   = ((CW > 8) ? CW : 8) + 1;
  localparam int MW   = AW + PIN_BITS;
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  fsm_t state, state_next;

  logic [7:0]          max_scan;
  logic [ENTRIES-1:0]  valid;
  logic [CW-1:0]       occ;
  logic [CW-1:0]       cnt;
  logic                p_live;
  logic [AW-1:0]       p_idx;

  // latched transaction
  logic [2:0]          op;
  logic [KEY_BITS-1:0] k;

  // scan results
  logic                found;
  logic [AW-1:0]       fslot;
  logic [AW-1:0]       frank;
  logic                free_found;
  logic [AW-1:0]       free_slot;
  logic [KEY_BITS-1:0] ev_key;

  upd_ctrl_t           ctrl;
  logic [1:0]          res_status;

  // decision from the scan results
  upd_mode_t           dec_mode;
  logic [1:0]          dec_status;

  // ram ports
  logic [KEY_BITS-1:0] key_rdata;
  logic                key_we;
  logic [MW-1:0]       meta_rdata, meta_wdata;
  logic                meta_we;
  logic [AW-1:0]       rank_rd, rank_wr;
  logic [PIN_BITS-1:0] pins_rd, pins_wr;

  logic                accept;
  logic                sweep_end;
  logic [LW-1:0]       scan_lo;
  logic                cand;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign sweep_end = (cnt == FULL_CNT) && p_live;

  assign rank_rd = meta_rdata[MW-1:PIN_BITS];
  assign pins_rd = meta_rdata[PIN_BITS-1:0];

  // lowest rank an eviction may look at: occ - max_scan, floored at zero
  assign scan_lo = (LW'(occ) > LW'(max_scan)) ? (LW'(occ) - LW'(max_scan)) : '0;

  // unpinned, within the scan window, older than the best so far
  assign cand = valid[p_idx] && (pins_rd == '0) && (LW'(rank_rd) >= scan_lo) &&
                (!found || rank_rd > frank);

  lrupc_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (free_slot),
    .wdata (k),
    .raddr (cnt[AW-1:0]),
    .rdata (key_rdata)
  );

  lrupc_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (p_idx),
    .wdata (meta_wdata),
    .raddr (cnt[AW-1:0]),
    .rdata (meta_rdata)
  );

  lrupc_update #(.AW(AW), .PIN_BITS(PIN_BITS)) u_update (
    .ctrl      (ctrl),
    .idx       (p_idx),
    .valid     (valid[p_idx]),
    .fslot     (fslot),
    .frank     (frank),
    .free_slot (free_slot),
    .rank_in   (rank_rd),
    .pins_in   (pins_rd),
    .rank_out  (rank_wr),
    .pins_out  (pins_wr)
  );

  assign meta_wdata = {rank_wr, pins_wr};
  assign meta_we    = (state == S_UPDATE) && p_live;
  assign key_we     = (state == S_DONE) && (ctrl.mode == UPD_INSERT);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_SCAN;
      S_SCAN:   if (sweep_end) state_next = S_DECIDE;
      S_DECIDE: state_next = S_UPDATE;
      S_UPDATE: if (sweep_end) state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_scan <= 8'(MAX_SCAN_RESET);
    end else if (cfg_valid && cfg_ready) begin
      max_scan <= cfg_data;
    end
  end

  // sweep counter and registered-read pipeline tag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      p_live <= 1'b0;
    end else if (state == S_SCAN || state == S_UPDATE) begin
      if (sweep_end) begin
        cnt    <= '0;
        p_live <= 1'b0;
      end else begin
        p_live <= (cnt != FULL_CNT);
        if (cnt != FULL_CNT) begin
          cnt <= cnt + 1'b1;
        end
      end
    end else begin
      cnt    <= '0;
      p_live <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    p_idx <= cnt[AW-1:0];
  end

  // update mode and answer for the latched operation
  always_comb begin
    dec_mode   = UPD_NONE;
    dec_status = ST_OK;
    case (op)
      OP_ACCESS: begin
        if (found) begin
          dec_mode = UPD_FRONT;
        end else if (occ == FULL_CNT) begin
          dec_status = ST_FULL;
        end else begin
          dec_mode = UPD_INSERT;
        end
      end
      OP_EVICT: begin
        if (found) begin
          dec_mode = UPD_REMOVE;
        end else begin
          dec_status = ST_NONE;
        end
      end
      OP_DELETE: begin
        if (found) dec_mode = UPD_REMOVE;
        else dec_status = ST_NOT_FOUND;
      end
      OP_REF: begin
        if (found) dec_mode = UPD_FRONT;
        else dec_status = ST_NOT_FOUND;
      end
      OP_UNREF: begin
        if (found) dec_mode = UPD_UNREF;
        else dec_status = ST_NOT_FOUND;
      end
      default: begin
      end
    endcase
  end

  // latch transaction, gather scan results, decide
  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      ctrl       <= '{mode: UPD_NONE, is_ref: 1'b0};
      res_status <= ST_OK;
    end else begin
      if (accept) begin
        op         <= opcode;
        k          <= key[KEY_BITS-1:0];
        found      <= 1'b0;
        free_found <= 1'b0;
      end
      if (state == S_SCAN && p_live) begin
        if (op == OP_EVICT) begin
          if (cand) begin
            found  <= 1'b1;
            fslot  <= p_idx;
            frank  <= rank_rd;
            ev_key <= key_rdata;
          end
        end else if (valid[p_idx] && key_rdata == k) begin
          found <= 1'b1;
          fslot <= p_idx;
          frank <= rank_rd;
        end
        if (!valid[p_idx] && !free_found) begin
          free_found <= 1'b1;
          free_slot  <= p_idx;
        end
      end
      if (state == S_DECIDE) begin
        ctrl       <= '{mode: dec_mode, is_ref: (op == OP_REF)};
        res_status <= dec_status;
      end
    end
  end

  // commit valid bits and occupancy, emit the result
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      if (state == S_DONE) begin
        if (ctrl.mode == UPD_INSERT) begin
          valid[free_slot] <= 1'b1;
          occ              <= occ + 1'b1;
        end else if (ctrl.mode == UPD_REMOVE) begin
          valid[fslot] <= 1'b0;
          occ          <= occ - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      status     <= res_status;
      victim_key <= (op == OP_EVICT && found) ? 64'(ev_key) : 64'd0;
    end
  end

  // checks
  `ASSERT_ALWAYS(a_occ_bound, clk, rst, occ <= FULL_CNT, "occupancy above table depth")
  `ASSERT_ALWAYS(a_occ_match, clk, rst, CW'($countones(valid)) == occ,
    "occupancy does not match valid bits")
  `ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted transaction not busy")
  `ASSERT_NEXT(a_done_idle, clk, rst, state == S_DONE, done && !busy,
    "result not shown after commit")

endmodule
